FILE: design/swdb_pkg.sv
// ============================================================================
// swdb_pkg
// Shared types and register indexes for the sine set-point generator.
// ============================================================================
package swdb_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FREQUENCY_STEP = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND_BELOW = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND_ABOVE = 3'd5;

    typedef enum logic [1:0] {
        SIDE_EQUAL = 2'd0,
        SIDE_BELOW = 2'd1,
        SIDE_ABOVE = 2'd2
    } side_t;

    typedef struct packed {
        logic        [14:0] amplitude;
        logic        [31:0] frequency_step;
        logic        [15:0] phase_offset;
        logic signed [15:0] center;
        logic        [14:0] deadband_below;
        logic        [14:0] deadband_above;
        logic signed [16:0] amp_eff;
    } cfg_t;

endpackage

FILE: design/swdb_regs.sv
// ============================================================================
// swdb_regs
// Configuration register file; also holds the registered effective amplitude.
// ============================================================================
module swdb_regs
    import swdb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AMPLITUDE:      cfg_next.amplitude      = cfg_data[14:0];
                REG_FREQUENCY_STEP: cfg_next.frequency_step = cfg_data[31:0];
                REG_PHASE_OFFSET:   cfg_next.phase_offset   = cfg_data[15:0];
                REG_CENTER:         cfg_next.center         = $signed(cfg_data[15:0]);
                REG_DEADBAND_BELOW: cfg_next.deadband_below = cfg_data[14:0];
                REG_DEADBAND_ABOVE: cfg_next.deadband_above = cfg_data[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
        cfg_next.amp_eff = $signed({2'b00, cfg_reg.amplitude})
                         - $signed({2'b00, cfg_reg.deadband_below})
                         - $signed({2'b00, cfg_reg.deadband_above});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/swdb_sine_rom.sv
// ============================================================================
// swdb_sine_rom
// Quarter-wave sine magnitude ROM, registered read with enable.
// ============================================================================
module swdb_sine_rom
    import swdb_pkg::*;
#(
    parameter int TABLE_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [TABLE_BITS-2:0] addr,
    output logic [14:0]           mag
);

    localparam int  QUARTER = 1 << (TABLE_BITS - 2);
    localparam int  QDEPTH  = QUARTER + 1;
    localparam real PEAK    = 32767.0;
    localparam real HALF_PI = 1.57079632679489661923;
    localparam real STEP    = HALF_PI / real'(QUARTER);

    typedef logic [14:0] qtab_t [QDEPTH];

    function automatic qtab_t build_qtab();
        qtab_t t;
        real   x;
        for (int k = 0; k < QDEPTH; k++)
        begin
            x    = PEAK * $sin(STEP * real'(k));
            t[k] = 15'($rtoi(x + 0.5));
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [14:0] mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= QTAB[addr];
        end
    end

    assign mag = mag_reg;

endmodule

FILE: design/sine_wave_deadband_generator.sv
// ============================================================================
// sine_wave_deadband_generator
// An accepted time word passes product, fold, ROM, multiply, output stages.
// Throughput: one word per cycle; stages fill bubbles, so input is stalled
// only when all five stages hold words and the output is stalled.
// Reset clears all valid bits and the configuration registers to zero;
// the sine table is a constant ROM and needs no clearing pass.
// ============================================================================
module sine_wave_deadband_generator
    import swdb_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [31:0]               time_ms,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [17:0]        set_point,
    output logic [1:0]                side
);

    localparam int TB = SINE_TABLE_BITS;
    localparam logic [TB-2:0] QUARTER = {1'b1, {(TB-2){1'b0}}};
    localparam logic [TB-1:0] HALF    = {1'b1, {(TB-1){1'b0}}};

    cfg_t cfg;

    swdb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !rsp_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req_stall = !en1;
    assign rsp_valid = v5_reg;

    // stage 1: low word of frequency * time
    logic [31:0] plo_reg, plo_next;
    assign plo_next = cfg.frequency_step * time_ms;

    // stage 2: phase, fold into quarter wave
    logic [31:0]   phase;
    logic [TB-1:0] idx;
    logic [TB-2:0] h_raw;
    logic [TB-2:0] addr_reg, addr_next;
    logic          neg2_reg;

    assign phase     = plo_reg + {cfg.phase_offset, 16'h0000};
    assign idx       = phase[31 -: TB];
    assign h_raw     = idx[TB-2:0];
    assign addr_next = (h_raw > QUARTER) ? (TB-1)'(HALF - {1'b0, h_raw}) : h_raw;

    // stage 3: ROM read
    logic [14:0] mag;
    logic        neg3_reg;

    swdb_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .clk  (clk),
        .en   (en3),
        .addr (addr_reg),
        .mag  (mag)
    );

    // stage 4: amplitude multiply
    logic signed [15:0] sine;
    logic signed [32:0] prod_reg, prod_next;

    assign sine      = neg3_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign prod_next = 33'(cfg.amp_eff) * 33'(sine);

    // stage 5: center and deadband
    logic signed [17:0] wave;
    logic signed [19:0] dlt;
    logic signed [19:0] value;
    side_t              side_next, side_reg;
    logic signed [17:0] set_point_reg;

    assign wave = prod_reg[32:15];

    always_comb
    begin
        priority if (wave < 0)
        begin
            side_next = SIDE_BELOW;
            dlt       = -$signed({5'b0, cfg.deadband_below});
        end
        else if (wave > 0)
        begin
            side_next = SIDE_ABOVE;
            dlt       = $signed({5'b0, cfg.deadband_above});
        end
        else
        begin
            side_next = SIDE_EQUAL;
            dlt       = '0;
        end
    end

    assign value = 20'(wave) + 20'(cfg.center) + dlt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= req_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            plo_reg <= plo_next;
        end
        if (en2)
        begin
            addr_reg <= addr_next;
            neg2_reg <= idx[TB-1];
        end
        if (en3)
        begin
            neg3_reg <= neg2_reg;
        end
        if (en4)
        begin
            prod_reg <= prod_next;
        end
        if (en5)
        begin
            set_point_reg <= value[17:0];
            side_reg      <= side_next;
        end
    end

    assign set_point = set_point_reg;
    assign side      = side_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && rsp_stall))
        else $error("input stalled with a free stage");

    a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v5_reg) |-> $past(v4_reg))
        else $error("output word without a stage 4 word");

    a_rom_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("ROM stage word without a stage 2 word");

endmodule
